[rtl/gba_pkg.sv]
package gba_pkg;

	localparam int MAX_GROUPS = 8;
	localparam int MAX_ENTRIES = 32768;
	localparam int WORD_BITS = 64;
	localparam int GRANULE = 8;

	localparam int GRP_W = $clog2(MAX_GROUPS);
	localparam int NGRP_W = $clog2(MAX_GROUPS + 1);
	localparam int WORDS_PER_GROUP = MAX_ENTRIES / WORD_BITS;
	localparam int WIDX_W = $clog2(WORDS_PER_GROUP);
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int OFF_W = $clog2(MAX_ENTRIES);
	localparam int ADDR_W = GRP_W + WIDX_W;
	localparam int DEPTH = MAX_GROUPS * WORDS_PER_GROUP;

	localparam int INDEX_W = 18;
	localparam int ENT_W = 16;
	localparam int TOTAL_W = 19;
	localparam int STATUS_W = 3;
	localparam int GROUPS_W = 4;
	localparam int CFG_W = 18;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd4;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_ZERO = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	localparam logic [1:0] REG_GROUPS = 2'd0;
	localparam logic [1:0] REG_ENTRIES = 2'd1;
	localparam logic [1:0] REG_FLOOR = 2'd2;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] free_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  granted_index;
		logic [ENT_W-1:0]    group_free_after;
		logic [TOTAL_W-1:0]  total_free_after;
	} rsp_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [NGRP_W-1:0]  groups;
		logic [ENT_W-1:0]   entries;
		logic [INDEX_W-1:0] floor;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [GRP_W-1:0] grp;
		logic [OFF_W-1:0] off;
	} q_entry_t;

endpackage

[rtl/gba_front.sv]
module gba_front (
	input  logic              clk,
	input  logic              arst_n,
	input  gba_pkg::cfg_t     cfg,
	input  logic              accept,
	input  gba_pkg::req_t     req,
	output logic              div_busy,
	output logic              push,
	output gba_pkg::q_entry_t entry
);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_DIV = 1'b1;

	logic                            state_q;
	logic [gba_pkg::INDEX_W-1:0]     rem_q;
	logic [gba_pkg::NGRP_W-1:0]      grp_q;
	logic                            rem_lt;
	logic                            at_end;

	assign rem_lt = rem_q < gba_pkg::INDEX_W'(cfg.entries);
	assign at_end = grp_q == cfg.groups;
	assign div_busy = state_q == F_DIV;

	always_comb begin
		push = 1'b0;
		entry.kind = gba_pkg::KIND_ALLOC;
		entry.grp = '0;
		entry.off = '0;
		if (state_q == F_IDLE) begin
			if (accept) begin
				if (req.op == gba_pkg::OP_ALLOC) begin
					push = 1'b1;
				end else if (req.free_index == '0) begin
					push = 1'b1;
					entry.kind = gba_pkg::KIND_ZERO;
				end else if (req.free_index < cfg.floor) begin
					push = 1'b1;
					entry.kind = gba_pkg::KIND_BAD;
				end
			end
		end else begin
			if (at_end) begin
				push = 1'b1;
				entry.kind = gba_pkg::KIND_BAD;
			end else if (rem_lt) begin
				push = 1'b1;
				entry.kind = gba_pkg::KIND_FREE;
				entry.grp = grp_q[gba_pkg::GRP_W-1:0];
				entry.off = rem_q[gba_pkg::OFF_W-1:0];
			end
		end
	end

	// index / entries by repeated subtraction, one group a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else if (state_q == F_IDLE) begin
			if (accept && req.op == gba_pkg::OP_FREE && req.free_index != '0 &&
			    !(req.free_index < cfg.floor)) begin
				state_q <= F_DIV;
			end
		end else if (push) begin
			state_q <= F_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			rem_q <= req.free_index;
			grp_q <= '0;
		end else begin
			rem_q <= rem_q - gba_pkg::INDEX_W'(cfg.entries);
			grp_q <= grp_q + 1'b1;
		end
	end

endmodule

[rtl/gba_queue.sv]
module gba_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gba_pkg::q_entry_t push_entry,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output gba_pkg::q_entry_t head
);

	gba_pkg::q_entry_t slot_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        count_q;

	assign full = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_entry;
		end
	end

endmodule

[rtl/gba_back.sv]
module gba_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gba_pkg::cfg_t     cfg,
	input  logic              reinit,
	input  logic              q_valid,
	input  gba_pkg::q_entry_t q_head,
	output logic              q_pop,
	output logic              clearing,
	output logic              done,
	output gba_pkg::rsp_t     rsp
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_SCAN = 2'd1;
	localparam logic [1:0] B_FREE = 2'd2;

	localparam int AW = gba_pkg::ADDR_W;
	localparam int WB = gba_pkg::WORD_BITS;
	localparam int BW = gba_pkg::BIT_W;
	localparam int TW = gba_pkg::TOTAL_W;
	localparam int EW = gba_pkg::ENT_W;
	localparam int IW = gba_pkg::WIDX_W;

	logic [1:0]    state_q;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	logic [WB-1:0] mem [gba_pkg::DEPTH];
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [WB-1:0] rdata_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [WB-1:0] wd;

	logic [gba_pkg::NGRP_W-1:0] gen_g_q;
	logic [IW-1:0]              gen_w_q;
	logic [TW-1:0]              gen_base_q;
	logic                       gen_enter_q;
	logic                       gen_done_q;

	logic                      valid_s1;
	logic [gba_pkg::GRP_W-1:0] g_s1;
	logic [IW-1:0]             w_s1;
	logic [TW-1:0]             base_s1;
	logic [BW-1:0]             lo_s1;
	logic [BW-1:0]             hi_s1;

	logic [gba_pkg::GRP_W-1:0] fg_q;
	logic [gba_pkg::OFF_W-1:0] foff_q;

	logic [EW-1:0] cnt_q [gba_pkg::MAX_GROUPS];
	logic [TW-1:0] total_q;

	logic          done_q;
	gba_pkg::rsp_t rsp_q;

	// scan address generator
	logic [TW-1:0] floor_x;
	logic [TW-1:0] o0;
	logic          skip;
	logic [EW-1:0] e_m1;
	logic [IW-1:0] last_w;
	logic [IW-1:0] cur_w;
	logic          wrap;
	logic          issue;

	// word check
	logic [WB-1:0] cand;
	logic          hit;
	logic [BW-1:0] pick;
	logic [TW-1:0] grant;
	logic          full_now;
	logic          fbit;
	logic [AW-1:0] faddr;

	assign floor_x = TW'(cfg.floor);
	assign o0 = (floor_x > gen_base_q) ? floor_x - gen_base_q : '0;
	assign skip = gen_enter_q && (o0 >= TW'(cfg.entries));
	assign e_m1 = cfg.entries - 1'b1;
	assign last_w = e_m1[BW+IW-1:BW];
	assign cur_w = gen_enter_q ? o0[BW+IW-1:BW] : gen_w_q;
	assign wrap = skip || cur_w == last_w;
	assign issue = state_q == B_SCAN && !gen_done_q && !skip;

	always_comb begin
		cand = ~rdata_q & ({WB{1'b1}} << lo_s1) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_s1));
		if (!valid_s1 || state_q != B_SCAN) begin
			cand = '0;
		end
		pick = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pick = BW'(i);
			end
		end
	end

	assign hit = |cand;
	assign grant = base_s1 + TW'({w_s1, pick});
	assign full_now = state_q == B_SCAN && !hit && gen_done_q;
	assign faddr = {fg_q, foff_q[BW+IW-1:BW]};
	assign fbit = rdata_q[foff_q[BW-1:0]];

	assign q_pop = state_q == B_IDLE && !clearing_q && !reinit && q_valid;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = {gen_g_q[gba_pkg::GRP_W-1:0], cur_w};
		if (q_pop && q_head.kind == gba_pkg::KIND_FREE) begin
			rd_en = 1'b1;
			rd_addr = {q_head.grp, q_head.off[BW+IW-1:BW]};
		end else if (issue) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = clr_cnt_q;
		wd = '0;
		if (clearing_q) begin
			we = 1'b1;
		end else if (hit) begin
			we = 1'b1;
			wa = {g_s1, w_s1};
			wd = rdata_q | (WB'(1) << pick);
		end else if (state_q == B_FREE && fbit) begin
			we = 1'b1;
			wa = faddr;
			wd = rdata_q & ~(WB'(1) << foff_q[BW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
			valid_s1 <= 1'b0;
			done_q <= 1'b0;
			total_q <= TW'(gba_pkg::MAX_GROUPS * gba_pkg::MAX_ENTRIES);
			for (int g = 0; g < gba_pkg::MAX_GROUPS; g++) begin
				cnt_q[g] <= EW'(gba_pkg::MAX_ENTRIES);
			end
		end else begin
			done_q <= 1'b0;
			valid_s1 <= issue;
			if (reinit) begin
				clearing_q <= 1'b1;
				clr_cnt_q <= '0;
				state_q <= B_IDLE;
				valid_s1 <= 1'b0;
			end else if (clearing_q) begin
				if (clr_cnt_q == '0) begin
					total_q <= TW'(cfg.groups) * TW'(cfg.entries);
					for (int g = 0; g < gba_pkg::MAX_GROUPS; g++) begin
						cnt_q[g] <= (g < int'(cfg.groups)) ? cfg.entries : '0;
					end
				end
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == {AW{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end else begin
				case (state_q)
					B_IDLE: begin
						if (q_pop) begin
							case (q_head.kind)
								gba_pkg::KIND_ALLOC: begin
									state_q <= B_SCAN;
								end
								gba_pkg::KIND_FREE: begin
									state_q <= B_FREE;
								end
								gba_pkg::KIND_ZERO: begin
									done_q <= 1'b1;
								end
								default: begin
									done_q <= 1'b1;
								end
							endcase
						end
					end
					B_SCAN: begin
						if (hit) begin
							cnt_q[g_s1] <= cnt_q[g_s1] - 1'b1;
							total_q <= total_q - 1'b1;
							done_q <= 1'b1;
							state_q <= B_IDLE;
						end else if (full_now) begin
							done_q <= 1'b1;
							state_q <= B_IDLE;
						end
					end
					B_FREE: begin
						if (fbit) begin
							cnt_q[fg_q] <= cnt_q[fg_q] + 1'b1;
							total_q <= total_q + 1'b1;
						end
						done_q <= 1'b1;
						state_q <= B_IDLE;
					end
					default: begin
						state_q <= B_IDLE;
					end
				endcase
			end
		end
	end

	// generator, pipeline tags and result payload
	always_ff @(posedge clk) begin
		if (state_q != B_SCAN) begin
			gen_g_q <= '0;
			gen_w_q <= '0;
			gen_base_q <= '0;
			gen_enter_q <= 1'b1;
			gen_done_q <= 1'b0;
		end else if (!gen_done_q) begin
			if (wrap) begin
				gen_g_q <= gen_g_q + 1'b1;
				gen_base_q <= gen_base_q + TW'(cfg.entries);
				gen_enter_q <= 1'b1;
				gen_done_q <= (gen_g_q + 1'b1) == cfg.groups;
			end else begin
				gen_w_q <= cur_w + 1'b1;
				gen_enter_q <= 1'b0;
			end
		end
		g_s1 <= gen_g_q[gba_pkg::GRP_W-1:0];
		w_s1 <= cur_w;
		base_s1 <= gen_base_q;
		lo_s1 <= gen_enter_q ? o0[BW-1:0] : '0;
		hi_s1 <= (cur_w == last_w) ? e_m1[BW-1:0] : BW'(WB - 1);
		if (q_pop) begin
			fg_q <= q_head.grp;
			foff_q <= q_head.off;
		end

		rsp_q.granted_index <= '0;
		rsp_q.group_free_after <= '0;
		rsp_q.total_free_after <= total_q;
		if (state_q == B_IDLE) begin
			if (q_head.kind == gba_pkg::KIND_ZERO) begin
				rsp_q.status <= gba_pkg::ST_ZERO;
				rsp_q.group_free_after <= cnt_q[0];
			end else begin
				rsp_q.status <= gba_pkg::ST_RANGE;
			end
		end else if (state_q == B_SCAN) begin
			if (hit) begin
				rsp_q.status <= gba_pkg::ST_OK;
				rsp_q.granted_index <= grant[gba_pkg::INDEX_W-1:0];
				rsp_q.group_free_after <= cnt_q[g_s1] - 1'b1;
				rsp_q.total_free_after <= total_q - 1'b1;
			end else begin
				rsp_q.status <= gba_pkg::ST_FULL;
			end
		end else if (fbit) begin
			rsp_q.status <= gba_pkg::ST_OK;
			rsp_q.group_free_after <= cnt_q[fg_q] + 1'b1;
			rsp_q.total_free_after <= total_q + 1'b1;
		end else begin
			rsp_q.status <= gba_pkg::ST_DOUBLE;
			rsp_q.group_free_after <= cnt_q[fg_q];
		end
	end

	assign clearing = clearing_q;
	assign done = done_q;
	assign rsp = rsp_q;

	a_no_scan_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SCAN |-> !clearing_q)
		else $error("scan running during clearing pass");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status != gba_pkg::ST_OK |-> rsp_q.granted_index == '0)
		else $error("index granted on failed request");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !done_q || $past(q_head.kind) == gba_pkg::KIND_ZERO ||
		$past(q_head.kind) == gba_pkg::KIND_BAD)
		else $error("result without finished work");

endmodule

[rtl/grouped_bitmap_allocator_core.sv]
// first-fit allocator over a grouped bitmap (4096 words of 64 bits). a request is taken when
// start is high and busy is low; its single result appears for exactly one cycle with done
// high and must be captured then, as the block cannot be held off. an allocate scans 64-bit
// bitmap words until it finds a free bit; the scan reads one word a cycle from the single
// bitmap memory. a free first splits the index by subtracting one group at a time, then does
// a read-modify-write of one word. requests are classified in the front, queued (two deep) and
// carried out in the back, so up to two further requests can be taken while another is
// running. after reset and after every write to one of the three configuration registers the
// bitmap is swept clear, one word a cycle, with busy held high. configuration is to be only
// written while idle; the user is bound by this, and the block itself does not enforce it.
module grouped_bitmap_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  gba_pkg::req_t                req,
	output logic                         done,
	output gba_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [gba_pkg::CFG_W-1:0]    cfg_wdata
);

	// raw register values as written
	logic [gba_pkg::GROUPS_W-1:0] groups_q;
	logic [gba_pkg::ENT_W-1:0]    entries_q;
	logic [gba_pkg::INDEX_W-1:0]  floor_q;
	gba_pkg::cfg_t                cfg;
	logic                         cfg_hit;

	logic              accept;
	logic              div_busy;
	logic              push;
	gba_pkg::q_entry_t push_entry;
	logic              q_full;
	logic              q_valid;
	gba_pkg::q_entry_t q_head;
	logic              q_pop;
	logic              clearing;

	// only the three known registers trigger a reinitialisation
	assign cfg_hit = cfg_we && (cfg_index == gba_pkg::REG_GROUPS ||
		cfg_index == gba_pkg::REG_ENTRIES || cfg_index == gba_pkg::REG_FLOOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= gba_pkg::GROUPS_W'(gba_pkg::MAX_GROUPS);
			entries_q <= gba_pkg::ENT_W'(gba_pkg::MAX_ENTRIES);
			floor_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gba_pkg::REG_GROUPS: begin
					groups_q <= cfg_wdata[gba_pkg::GROUPS_W-1:0];
				end
				gba_pkg::REG_ENTRIES: begin
					entries_q <= cfg_wdata[gba_pkg::ENT_W-1:0];
				end
				gba_pkg::REG_FLOOR: begin
					floor_q <= cfg_wdata[gba_pkg::INDEX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp group count and group size into their legal ranges
	always_comb begin
		if (groups_q == '0) begin
			cfg.groups = gba_pkg::NGRP_W'(1);
		end else if (groups_q > gba_pkg::GROUPS_W'(gba_pkg::MAX_GROUPS)) begin
			cfg.groups = gba_pkg::NGRP_W'(gba_pkg::MAX_GROUPS);
		end else begin
			cfg.groups = gba_pkg::NGRP_W'(groups_q);
		end
		if (entries_q < gba_pkg::ENT_W'(gba_pkg::GRANULE)) begin
			cfg.entries = gba_pkg::ENT_W'(gba_pkg::GRANULE);
		end else if (entries_q > gba_pkg::ENT_W'(gba_pkg::MAX_ENTRIES)) begin
			cfg.entries = gba_pkg::ENT_W'(gba_pkg::MAX_ENTRIES);
		end else begin
			cfg.entries = entries_q;
		end
		cfg.floor = floor_q;
	end

	// busy while sweeping, splitting an index, or with no queue space
	assign busy = clearing || div_busy || q_full;
	assign accept = start && !busy;

	gba_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.req      (req),
		.div_busy (div_busy),
		.push     (push),
		.entry    (push_entry)
	);

	gba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.valid      (q_valid),
		.head       (q_head)
	);

	gba_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.reinit   (cfg_hit),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.done     (done),
		.rsp      (rsp)
	);

endmodule
